FILE: sv/rrvc_pkg.sv
// Package for the raster run to vector command unit.
// Holds the command byte codes, register indexes, reset values and shared types.
// No dependencies.
package rrvc_pkg;

  localparam int unsigned DefaultMaxDimension = 1024;
  localparam int unsigned CfgDimW    = 11;
  localparam int unsigned CoordW     = 10;
  localparam int unsigned ModeW      = 8;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned CfgDataW   = 11;
  localparam int unsigned QueueDepth = 4;

  localparam logic [CfgIndexW-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_X_OFFSET     = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_Y_ORIGIN     = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_DRAW_MODE    = 3'd4;

  localparam logic [CfgDimW-1:0] RST_IMAGE_WIDTH  = 11'd500;
  localparam logic [CfgDimW-1:0] RST_IMAGE_HEIGHT = 11'd500;
  localparam logic [CoordW-1:0]  RST_X_OFFSET     = 10'd262;
  localparam logic [CoordW-1:0]  RST_Y_ORIGIN     = 10'd700;
  localparam logic [ModeW-1:0]   RST_DRAW_MODE    = 8'h60;

  localparam logic [7:0] CODE_GS     = 8'h1D;
  localparam logic [7:0] CODE_ESC    = 8'h1B;
  localparam logic [7:0] CODE_US     = 8'h1F;
  localparam logic [7:0] TAG_HIGH    = 8'h20;
  localparam logic [7:0] TAG_LOW_Y   = 8'h60;
  localparam logic [7:0] TAG_LOW_X   = 8'h40;

  typedef struct packed {
    logic [CfgDimW-1:0] image_width;
    logic [CfgDimW-1:0] image_height;
    logic [CoordW-1:0]  x_offset;
    logic [CoordW-1:0]  y_origin;
    logic [ModeW-1:0]   draw_mode;
  } cfg_t;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x_end;
    logic [CoordW-1:0] x_start;
  } line_cmd_t;

endpackage

FILE: sv/raster_runs_to_vector_commands_unit.sv
// Raster run to vector command unit: pixels in, 12-word line commands out.
// A run's closing pixel pushes its command into the queue; words leave from an output register.
// Throughput: one pixel per cycle while the four-entry command queue has room; the output
// side sends one word per cycle while out_tready is high and a command is queued.
// Reset (synchronous, active low) clears position, run and queue state and restores
// the register reset values.
module raster_runs_to_vector_commands_unit #(
  parameter int unsigned MAX_DIMENSION = rrvc_pkg::DefaultMaxDimension
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] pixel_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] out_byte
  output logic                          out_tuser,  // [0] end_of_command
  input  logic                          cfg_we,
  input  logic [rrvc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [rrvc_pkg::CfgDataW-1:0]  cfg_wdata
);
  import rrvc_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  line_cmd_t push_cmd, head_cmd;
  logic      cmd_push, head_pop, queue_full, queue_empty;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_nxt.image_width  = CfgDimW'(cfg_wdata);
        REG_IMAGE_HEIGHT: cfg_nxt.image_height = CfgDimW'(cfg_wdata);
        REG_X_OFFSET:     cfg_nxt.x_offset     = cfg_wdata[CoordW-1:0];
        REG_Y_ORIGIN:     cfg_nxt.y_origin     = cfg_wdata[CoordW-1:0];
        REG_DRAW_MODE:    cfg_nxt.draw_mode    = cfg_wdata[ModeW-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= RST_IMAGE_WIDTH;
      cfg_r.image_height <= RST_IMAGE_HEIGHT;
      cfg_r.x_offset     <= RST_X_OFFSET;
      cfg_r.y_origin     <= RST_Y_ORIGIN;
      cfg_r.draw_mode    <= RST_DRAW_MODE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rrvc_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .pix_valid  (in_tvalid),
    .pix_byte   (in_tdata),
    .queue_full (queue_full),
    .pix_ready  (in_tready),
    .cmd_push   (cmd_push),
    .cmd        (push_cmd)
  );

  rrvc_queue #(
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .pop      (head_pop),
    .head_cmd (head_cmd),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  rrvc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_cmd   (head_cmd),
    .head_valid (!queue_empty),
    .head_pop   (head_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: sv/rrvc_front.sv
// Front end: tracks column and row, finds runs of dark pixels and builds line commands.
// Depends on rrvc_pkg.
module rrvc_front #(
  parameter int unsigned MAX_DIMENSION = rrvc_pkg::DefaultMaxDimension
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rrvc_pkg::cfg_t    cfg,
  input  logic              pix_valid,
  input  logic [7:0]        pix_byte,
  input  logic              queue_full,
  output logic              pix_ready,
  output logic              cmd_push,
  output rrvc_pkg::line_cmd_t cmd
);
  import rrvc_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_DIMENSION);
  localparam int unsigned DimW = $clog2(MAX_DIMENSION + 1);

  logic [PosW-1:0] col_r, col_nxt;
  logic [PosW-1:0] row_r, row_nxt;
  logic [PosW-1:0] start_r, start_nxt;
  logic            run_open_r, run_open_nxt;

  logic [DimW-1:0] width_eff, height_eff, col_plus, row_plus;
  logic            accept, dark, last_col, last_row, close_nd, close_last, emit;
  logic [PosW-1:0] start_sel;
  logic [CoordW-1:0] end_col;

  always_comb begin
    if (cfg.image_width == '0) begin
      width_eff = DimW'(1);
    end else if (cfg.image_width > CfgDimW'(MAX_DIMENSION)) begin
      width_eff = DimW'(MAX_DIMENSION);
    end else begin
      width_eff = DimW'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      height_eff = DimW'(1);
    end else if (cfg.image_height > CfgDimW'(MAX_DIMENSION)) begin
      height_eff = DimW'(MAX_DIMENSION);
    end else begin
      height_eff = DimW'(cfg.image_height);
    end
  end

  assign pix_ready  = !queue_full;
  assign accept     = pix_valid && pix_ready;
  assign dark       = col_r[0] ? (pix_byte[7:4] == 4'd0) : (pix_byte == 8'd0);
  assign col_plus   = DimW'(col_r) + DimW'(1);
  assign row_plus   = DimW'(row_r) + DimW'(1);
  assign last_col   = col_plus >= width_eff;
  assign last_row   = row_plus >= height_eff;
  assign close_nd   = !dark && run_open_r;
  assign close_last = last_col && (run_open_r || dark);
  assign emit       = close_nd || close_last;
  assign start_sel  = run_open_r ? start_r : col_r;
  assign end_col    = close_nd ? (CoordW'(col_r) - CoordW'(1)) : CoordW'(col_r);

  assign cmd_push      = accept && emit;
  assign cmd.mode      = cfg.draw_mode;
  assign cmd.y         = cfg.y_origin - CoordW'(row_r);
  assign cmd.x_start   = cfg.x_offset + CoordW'(start_sel);
  assign cmd.x_end     = cfg.x_offset + end_col;

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    start_nxt    = start_r;
    run_open_nxt = run_open_r;
    if (accept) begin
      if (dark && !run_open_r) begin
        start_nxt = col_r;
      end
      run_open_nxt = emit ? 1'b0 : (run_open_r || dark);
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : PosW'(row_plus);
      end else begin
        col_nxt = PosW'(col_plus);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      start_r    <= '0;
      run_open_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      start_r    <= start_nxt;
      run_open_r <= run_open_nxt;
    end
  end

endmodule

FILE: sv/rrvc_queue.sv
// Short queue of pending line commands between the front and back ends.
// Depends on rrvc_pkg.
module rrvc_queue #(
  parameter int unsigned DEPTH = rrvc_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rrvc_pkg::line_cmd_t push_cmd,
  input  logic                pop,
  output rrvc_pkg::line_cmd_t head_cmd,
  output logic                full,
  output logic                empty
);
  import rrvc_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  line_cmd_t       entry_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = count_r == CntW'(DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CntW'(1);
      2'b01:   count_nxt = count_r - CntW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: sv/rrvc_back.sv
// Back end: serializes each queued line command into twelve output words.
// Depends on rrvc_pkg.
module rrvc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rrvc_pkg::line_cmd_t head_cmd,
  input  logic                head_valid,
  output logic                head_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tuser
);
  import rrvc_pkg::*;

  typedef enum logic [3:0] {
    SLOT_GS, SLOT_ESC, SLOT_MODE,
    SLOT_Y0_HI, SLOT_Y0_LO, SLOT_X0_HI, SLOT_X0_LO,
    SLOT_Y1_HI, SLOT_Y1_LO, SLOT_X1_HI, SLOT_X1_LO,
    SLOT_US
  } cmd_slot_t;

  cmd_slot_t  slot_r, slot_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] data_r, data_nxt;
  logic       last_r, last_nxt;
  logic       load;
  logic [7:0] byte_sel;

  assign load     = head_valid && (!valid_r || out_tready);
  assign head_pop = load && (slot_r == SLOT_US);

  always_comb begin
    unique case (slot_r)
      SLOT_GS:    byte_sel = CODE_GS;
      SLOT_ESC:   byte_sel = CODE_ESC;
      SLOT_MODE:  byte_sel = head_cmd.mode;
      SLOT_Y0_HI,
      SLOT_Y1_HI: byte_sel = TAG_HIGH | 8'(head_cmd.y[9:5]);
      SLOT_Y0_LO,
      SLOT_Y1_LO: byte_sel = TAG_LOW_Y | 8'(head_cmd.y[4:0]);
      SLOT_X0_HI: byte_sel = TAG_HIGH | 8'(head_cmd.x_start[9:5]);
      SLOT_X0_LO: byte_sel = TAG_LOW_X | 8'(head_cmd.x_start[4:0]);
      SLOT_X1_HI: byte_sel = TAG_HIGH | 8'(head_cmd.x_end[9:5]);
      SLOT_X1_LO: byte_sel = TAG_LOW_X | 8'(head_cmd.x_end[4:0]);
      SLOT_US:    byte_sel = CODE_US;
      default:    byte_sel = CODE_US;
    endcase
  end

  always_comb begin
    slot_nxt  = slot_r;
    valid_nxt = valid_r;
    data_nxt  = data_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = byte_sel;
      last_nxt  = slot_r == SLOT_US;
      slot_nxt  = (slot_r == SLOT_US) ? SLOT_GS : cmd_slot_t'(slot_r + 4'd1);
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= SLOT_GS;
      valid_r <= 1'b0;
    end else begin
      slot_r  <= slot_nxt;
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = last_r;

endmodule

FILE: tb/rrvc_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the raster run to vector command unit testbench.
// Predicts the command words from the accepted pixels and checks them; depends on rrvc_pkg.
package rrvc_tb_pkg;
  import rrvc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cmd_word_t;

  class line_cmd_scoreboard;
    logic [CfgDimW-1:0] width_reg;
    logic [CfgDimW-1:0] height_reg;
    logic [CoordW-1:0]  x_off;
    logic [CoordW-1:0]  y_org;
    logic [ModeW-1:0]   mode;
    logic [CoordW-1:0]  col;
    logic [CoordW-1:0]  row;
    logic [CoordW-1:0]  run_col;
    bit                 run_open;
    cmd_word_t          pending_words[$];
    int unsigned        failures;

    function new();
      width_reg  = RST_IMAGE_WIDTH;
      height_reg = RST_IMAGE_HEIGHT;
      x_off      = RST_X_OFFSET;
      y_org      = RST_Y_ORIGIN;
      mode       = RST_DRAW_MODE;
      col        = '0;
      row        = '0;
      run_col    = '0;
      run_open   = 1'b0;
      failures   = 0;
    endfunction

    function void write_register(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg  = value;
        REG_IMAGE_HEIGHT: height_reg = value;
        REG_X_OFFSET:     x_off      = value[CoordW-1:0];
        REG_Y_ORIGIN:     y_org      = value[CoordW-1:0];
        REG_DRAW_MODE:    mode       = value[ModeW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(logic [CfgDimW-1:0] v);
      if (v == 0) return 1;
      if (v > DefaultMaxDimension) return DefaultMaxDimension;
      return v;
    endfunction

    function void push_word(logic [7:0] data, logic last);
      pending_words.push_back({data, last});
    endfunction

    function void push_point(logic [CoordW-1:0] x, logic [CoordW-1:0] y);
      push_word(TAG_HIGH | {3'b000, y[9:5]}, 1'b0);
      push_word(TAG_LOW_Y | {3'b000, y[4:0]}, 1'b0);
      push_word(TAG_HIGH | {3'b000, x[9:5]}, 1'b0);
      push_word(TAG_LOW_X | {3'b000, x[4:0]}, 1'b0);
    endfunction

    function void queue_line(logic [CoordW-1:0] first_col, logic [CoordW-1:0] last_col);
      logic [CoordW-1:0] y;
      y = y_org - row;
      push_word(CODE_GS, 1'b0);
      push_word(CODE_ESC, 1'b0);
      push_word(mode, 1'b0);
      push_point(x_off + first_col, y);
      push_point(x_off + last_col, y);
      push_word(CODE_US, 1'b1);
    endfunction

    function void note_pixel(logic [7:0] pixel);
      int unsigned w;
      int unsigned h;
      logic [7:0]  level;
      bit          at_row_end;
      bit          dark;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      at_row_end = (col + 32'd1) >= w;
      level = col[0] ? (pixel >> 4) : pixel;
      dark = (level == 8'h00);
      if (dark && !run_open) begin
        run_open = 1'b1;
        run_col  = col;
      end
      if (!dark && run_open) begin
        queue_line(run_col, col - 1'b1);
        run_open = 1'b0;
      end
      if (at_row_end && run_open) begin
        queue_line(run_col, col);
        run_open = 1'b0;
      end
      if (at_row_end) begin
        col = '0;
        row = ((row + 32'd1) >= h) ? '0 : row + 1'b1;
      end else begin
        col = col + 1'b1;
      end
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_word(logic [7:0] data, logic last);
      cmd_word_t want;
      if (pending_words.size() == 0) begin
        note_failure($sformatf("unexpected word %02h last %0b", data, last));
        return;
      end
      want = pending_words.pop_front();
      if (want.data !== data || want.last !== last)
        note_failure($sformatf("word mismatch: expected %02h last %0b, got %02h last %0b",
                               want.data, want.last, data, last));
    endfunction

    function int unsigned outstanding();
      return pending_words.size();
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the testbench for raster_runs_to_vector_commands_unit.
// Drives pixel words and register writes, checks the command words; depends on rrvc_pkg and
// rrvc_tb_pkg.
module tb_top;
  import rrvc_pkg::*;
  import rrvc_tb_pkg::*;

  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned PhaseItems   = 35;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic                 out_tuser;
  logic                 cfg_we     = 1'b0;
  logic [CfgIndexW-1:0] cfg_index  = '0;
  logic [CfgDataW-1:0]  cfg_wdata  = '0;

  bit                   steady       = 1'b0;
  bit                   hold_request = 1'b0;
  int unsigned          cycle_count  = 0;
  line_cmd_scoreboard   scoreboard;

  raster_runs_to_vector_commands_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] random_pixel();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'h00;
    if (r < 50) return 8'($urandom_range(1, 15));
    if (r < 60) return 8'($urandom_range(1, 15) << 4);
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(input logic [7:0] pixel);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pixel;
    do @(posedge clk); while (!in_tready);
    scoreboard.note_pixel(pixel);
  endtask

  // Stops the pixel input and waits until every predicted command word has been checked, then lets the block settle.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (scoreboard.outstanding() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CfgDataW'(value);
    @(posedge clk);
    scoreboard.write_register(idx, CfgDataW'(value));
  endtask

  task automatic random_settings(input bit pressure);
    int unsigned r;
    int unsigned width_val;
    int unsigned height_val;
    if (pressure) begin
      width_val  = 64;
      height_val = 4;
    end else begin
      r = $urandom_range(0, 9);
      width_val = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 2047 : (r == 3) ? 1024 :
                  $urandom_range(2, 24);
      r = $urandom_range(0, 9);
      height_val = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 1024 : (r == 3) ? 1500 :
                   $urandom_range(2, 8);
    end
    write_reg(REG_IMAGE_WIDTH, width_val);
    write_reg(REG_IMAGE_HEIGHT, height_val);
    r = $urandom_range(0, 3);
    write_reg(REG_X_OFFSET, (r == 0) ? 0 : (r == 1) ? 1023 : $urandom_range(0, 2047));
    r = $urandom_range(0, 3);
    write_reg(REG_Y_ORIGIN, (r == 0) ? 0 : (r == 1) ? 1023 : $urandom_range(0, 2047));
    r = $urandom_range(0, 3);
    write_reg(REG_DRAW_MODE, (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(0, 2047));
    cfg_we <= 1'b0;
  endtask

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : word_sink
    int unsigned stall_left;
    bit          hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) scoreboard.check_word(out_tdata, out_tuser);
      if (hold_request && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = LongHold;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    scoreboard = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: short runs, odd columns judged by the upper nibble only,
    // and a run left open across the register writes below.
    send_pixel(8'h00);
    send_pixel(8'h0F);
    send_pixel(8'hFF);
    send_pixel(8'hF0);
    send_pixel(8'h01);
    send_pixel(8'h0F);
    send_pixel(8'h80);
    send_pixel(8'h00);
    send_pixel(8'h00);

    // Width drops below the current column, so the open run closes on the next word.
    // The x offset and y origin extremes make both coordinates wrap.
    settle();
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 2);
    write_reg(REG_X_OFFSET, 1023);
    write_reg(REG_Y_ORIGIN, 0);
    write_reg(REG_DRAW_MODE, 255);
    for (int idx = int'(REG_DRAW_MODE) + 1; idx < (1 << CfgIndexW); idx++)
      write_reg(CfgIndexW'(idx), $urandom_range(0, 2047));
    cfg_we <= 1'b0;
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h00);
    send_pixel(8'h00);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h0F);

    // A width of zero acts as one: every dark pixel is a whole run.
    settle();
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 1024);
    cfg_we <= 1'b0;
    send_pixel(8'h00);
    send_pixel(8'h55);
    send_pixel(8'h00);

    // Oversized width is limited to the maximum, zero height acts as one.
    settle();
    write_reg(REG_IMAGE_WIDTH, 2047);
    write_reg(REG_IMAGE_HEIGHT, 0);
    write_reg(REG_X_OFFSET, 0);
    write_reg(REG_Y_ORIGIN, 1023);
    write_reg(REG_DRAW_MODE, 0);
    cfg_we <= 1'b0;
    send_pixel(8'h00);
    send_pixel(8'h00);
    send_pixel(8'hAA);

    // Phase one alternates dark and light pixels while the sink holds off,
    // so the command queue fills and the input stalls.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      settle();
      random_settings(phase == 1);
      steady = (phase == 1) || (phase % 3 == 2);
      if (phase == 1) hold_request = 1'b1;
      for (int i = 0; i < PhaseItems; i++)
        send_pixel((phase == 1) ? ((i % 2 == 0) ? 8'h00 : 8'hFF) : random_pixel());
      steady = 1'b0;
    end

    settle();
    if (scoreboard.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/rrvc_pkg.sv
sv/rrvc_front.sv
sv/rrvc_queue.sv
sv/rrvc_back.sv
sv/raster_runs_to_vector_commands_unit.sv
tb/rrvc_tb_pkg.sv
tb/tb_top.sv
